// ----- hw/rtl/bse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants of the bubble sort engine
// Data width, default store depth, controller command and datapath status.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // commands from the controller to the datapath, at most one active a cycle
  typedef struct packed {
    logic load;        // store the accepted input beat
    logic rd_first;    // start a pass: read entry 0, clear index and swap flag
    logic pass_step;   // compare/swap the returned entry, read the next one
    logic pass_end;    // write the carried maximum at the top of the set
    logic out_rd;      // read the entry at the index for output
    logic out_ld;      // load the output register from the read data
  } bse_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_idx;    // index is the last entry of the set
    logic swapped;     // the current pass made a swap
  } bse_sts_t;

endpackage : bse_pkg
`default_nettype wire

// ----- hw/rtl/bse_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_in_if: input channel of the bubble sort engine
// Valid/ready handshake carrying one value of the set and its closing mark.
// ----------------------------------------------------------------------------
interface bse_in_if;

  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);

endinterface : bse_in_if
`default_nettype wire

// ----- hw/rtl/bse_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_out_if: result channel of the bubble sort engine
// Valid/ready handshake carrying one sorted value with its flags.
// ----------------------------------------------------------------------------
interface bse_out_if;

  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               last_result;
  logic               overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflowed, output ready);

endinterface : bse_out_if
`default_nettype wire

// ----- hw/rtl/bse_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_datapath: item store and compare/swap datapath
// Holds the item memory, fill count, overflow flag, the carry register that
// bubbles the maximum up during a pass, and the output beat register.
// ----------------------------------------------------------------------------
module bse_datapath #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bse_pkg::bse_cmd_t              cmd,
  output      bse_pkg::bse_sts_t              sts,
  input  wire logic signed [bse_pkg::DATA_W-1:0] in_value,
  output      logic signed [bse_pkg::DATA_W-1:0] out_sorted_value,
  output      logic                           out_last_result,
  output      logic                           out_overflowed
);
  import bse_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [DATA_W-1:0] mem_r [MAX_ITEMS];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] carry_r;
  logic                     swapped_r;
  logic [CW-1:0]            idx_r;
  logic [CW-1:0]            count_r;
  logic                     ovf_r;
  logic signed [DATA_W-1:0] out_val_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [CW-1:0]            idx_inc;
  logic [CW-1:0]            count_dec;
  logic                     room;
  logic                     greater;

  assign idx_inc   = idx_r + CW'(1);
  assign count_dec = count_r - CW'(1);
  assign room      = (count_r < CW'(MAX_ITEMS));
  assign greater   = (carry_r > rdata_r);

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_value;
    re    = 1'b0;
    raddr = idx_r[AW-1:0];
    if (cmd.load) begin
      we = room;
    end
    if (cmd.rd_first) begin
      re    = 1'b1;
      raddr = '0;
    end
    if (cmd.pass_step) begin
      re    = 1'b1;
      raddr = idx_inc[AW-1:0];
      if (idx_r != '0) begin
        we    = 1'b1;
        waddr = count_dec[AW-1:0];
        waddr = idx_r[AW-1:0] - AW'(1);
        wdata = greater ? rdata_r : carry_r;
      end
    end
    if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = count_dec[AW-1:0];
      wdata = carry_r;
    end
    if (cmd.out_rd) begin
      re = 1'b1;
    end
  end

  // item memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  // carry register and output beat payload
  always_ff @(posedge clk) begin
    if (cmd.pass_step && (idx_r == '0 || !greater)) begin
      carry_r <= rdata_r;
    end
    if (cmd.out_ld) begin
      out_val_r  <= rdata_r;
      out_last_r <= sts.last_idx;
      out_ovf_r  <= ovf_r;
    end
  end

  // control registers: fill count, overflow, index, swap flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      idx_r     <= '0;
      swapped_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.rd_first) begin
        idx_r     <= '0;
        swapped_r <= 1'b0;
      end
      if (cmd.pass_step) begin
        idx_r <= idx_inc;
        if (idx_r != '0 && greater) begin
          swapped_r <= 1'b1;
        end
      end
      if (cmd.pass_end) begin
        idx_r <= '0;
      end
      if (cmd.out_ld) begin
        idx_r <= idx_inc;
        if (sts.last_idx) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
    end
  end

  assign sts.last_idx = (idx_inc == count_r);
  assign sts.swapped  = swapped_r;

  assign out_sorted_value = out_val_r;
  assign out_last_result  = out_last_r;
  assign out_overflowed   = out_ovf_r;

endmodule : bse_datapath
`default_nettype wire

// ----- hw/rtl/bse_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_ctrl: sequencer of the bubble sort engine
// Loads the set, runs compare/swap passes until a clean pass, then streams
// the sorted entries out through the output register.
// ----------------------------------------------------------------------------
module bse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_item,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      bse_pkg::bse_cmd_t cmd,
  input  wire bse_pkg::bse_sts_t sts
);
  import bse_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS_START,
    S_PASS,
    S_PASS_END,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   in_beat;
  logic   slot_free;

  assign in_ready  = (state_r == S_LOAD);
  assign in_beat   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = in_beat;
        if (in_beat && in_last_item) begin
          state_nxt = S_PASS_START;
        end
      end
      S_PASS_START: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_PASS;
      end
      S_PASS: begin
        cmd.pass_step = 1'b1;
        if (sts.last_idx) begin
          state_nxt = S_PASS_END;
        end
      end
      S_PASS_END: begin
        cmd.pass_end = 1'b1;
        state_nxt    = sts.swapped ? S_PASS_START : S_OUT_RD;
      end
      S_OUT_RD: begin
        if (slot_free) begin
          cmd.out_rd = 1'b1;
          state_nxt  = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = sts.last_idx ? S_LOAD : S_OUT_RD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule : bse_ctrl
`default_nettype wire

// ----- hw/rtl/bubble_sort_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Loading accepts one input beat per cycle; the beat marked last starts the sort.
// Each pass over a set of n values makes one memory read per entry between
// a pass start and a pass end; up to n passes, ending at the first clean one.
// Results use the single memory read port; a read waits on an unaccepted beat.
// Reset clears the fill count, overflow flag and sequencer; store contents
// are left as they are and only entries written in the current set are used.
// ----------------------------------------------------------------------------
// bubble_sort_engine_core: bubble sort engine top level
// Joins the sequencer and the store datapath to the input and result channels.
// ----------------------------------------------------------------------------
module bubble_sort_engine_core #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bse_in_if.sink     in_bus,
  bse_out_if.source  out_bus
);
  import bse_pkg::*;

  bse_cmd_t cmd;
  bse_sts_t sts;

  bse_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_last_item (in_bus.last_item),
    .in_ready     (in_bus.ready),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  bse_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_bus.value),
    .out_sorted_value (out_bus.sorted_value),
    .out_last_result  (out_bus.last_result),
    .out_overflowed   (out_bus.overflowed)
  );

endmodule : bubble_sort_engine_core
`default_nettype wire

// ----- tb/bubble_sort_engine_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bubble_sort_engine_core_tb: self-checking bench for the bubble sort engine
// Loads sets of signed words through the input channel and keeps its own
// copy of each set. On the closing beat it sorts that copy and queues the
// sorted beats. Every result beat is checked in order against that queue.
// Covers single values, extremes, duplicates, a full store, dropped values,
// a long result stall and random sets. Both channels idle at random.
// ----------------------------------------------------------------------------
module bubble_sort_engine_core_tb;
  import bse_pkg::*;

  localparam int DEPTH         = MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS  = 8;
  localparam int LONG_HOLD     = 1200;    // cycles the receiver holds off
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 40000;
  localparam int TIMEOUT_NS    = 20000000;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;

  // one result beat as the engine should send it
  typedef struct {
    word_t value;
    bit    last;
    bit    dropped;
  } sorted_beat_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_t;

  logic clk;
  logic rst_n;

  bse_in_if  in_bus();
  bse_out_if out_bus();

  bubble_sort_engine_core #(
    .MAX_ITEMS(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bench copy of the set being loaded, and the sorted beats still owed
  word_t        set_values[$];
  bit           set_dropped;
  sorted_beat_t pending_sorted[$];
  int           mismatch_count;
  int           burst_left;
  bit           hold_request;
  rx_mode_t     rx_mode;

  // store one value (or drop it when full); on the closing beat sort and queue
  function automatic void load_and_sort(word_t value, bit closing);
    word_t        ordered[$];
    word_t        held;
    bit           swapped;
    sorted_beat_t beat;
    if (set_values.size() < DEPTH) set_values.push_back(value);
    else set_dropped = 1'b1;
    if (!closing) return;
    ordered = set_values;
    // adjacent compare-and-swap passes until one pass is clean
    do begin
      swapped = 1'b0;
      for (int k = 0; k + 1 < ordered.size(); k++) begin
        if (ordered[k] > ordered[k + 1]) begin
          held           = ordered[k];
          ordered[k]     = ordered[k + 1];
          ordered[k + 1] = held;
          swapped        = 1'b1;
        end
      end
    end while (swapped);
    foreach (ordered[k]) begin
      beat.value   = ordered[k];
      beat.last    = (k == ordered.size() - 1);
      beat.dropped = set_dropped;
      pending_sorted.push_back(beat);
    end
    set_values.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic word_t rand_value();
    word_t corner[4];
    int    pick;
    corner = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1};
    pick   = $urandom_range(0, 9);
    if (pick < 6) return word_t'($urandom);
    if (pick < 8) return word_t'($urandom_range(0, 8)) - 32'sd4;  // makes duplicates likely
    return corner[$urandom_range(0, 3)];
  endfunction

  // send one beat; the sender runs in bursts with random gaps between them
  task automatic send_beat(word_t value, bit closing);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.value     <= value;
    in_bus.last_item <= closing;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    load_and_sort(value, closing);
  endtask

  task automatic send_set(word_t vals[$]);
    foreach (vals[k]) send_beat(vals[k], k == vals.size() - 1);
  endtask

  // hold the sender until every owed result beat has arrived or the drain limit is reached
  task automatic wait_for_results();
    int waited;
    waited       = 0;
    in_bus.valid <= 1'b0;
    burst_left   = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_sorted.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  // result checker: each accepted beat against the oldest owed beat
  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected beat value=%0d last=%0b overflowed=%0b", $time,
                 out_bus.sorted_value, out_bus.last_result, out_bus.overflowed);
        mismatch_count++;
      end else begin
        want = pending_sorted.pop_front();
        if (out_bus.sorted_value !== want.value) begin
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   want.value, out_bus.sorted_value);
          mismatch_count++;
        end
        if (out_bus.last_result !== want.last) begin
          $display("%0t: last_result expected %0b actual %0b", $time,
                   want.last, out_bus.last_result);
          mismatch_count++;
        end
        if (out_bus.overflowed !== want.dropped) begin
          $display("%0t: overflowed expected %0b actual %0b", $time,
                   want.dropped, out_bus.overflowed);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: the stall pattern is re-picked at random; a request forces a long hold-off
  initial begin : receiver
    int hold_left;
    int cycle_no;
    hold_left     = 0;
    cycle_no      = 0;
    rx_mode       = RX_OPEN;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no % 150 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:  out_bus.ready <= 1'b1;
          RX_LIGHT: out_bus.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_bus.ready <= ($urandom_range(0, 2) == 0);
          default:  out_bus.ready <= (cycle_no % 4 < 2);
        endcase
      end
    end
  end

  // ---- tests ----

  task automatic test_single_values();
    word_t vals[$];
    vals = '{WORD_MIN};
    send_set(vals);
    vals = '{WORD_MAX};
    send_set(vals);
    wait_for_results();
  endtask

  task automatic test_extremes();
    word_t vals[$];
    vals = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1, 32'sd1, WORD_MIN, WORD_MAX};
    send_set(vals);
    wait_for_results();
  endtask

  // equal values stay put; reverse order needs the most passes
  task automatic test_duplicates_and_reverse();
    word_t vals[$];
    vals = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3};
    send_set(vals);
    vals = '{32'sd6, 32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1};
    send_set(vals);
    wait_for_results();
  endtask

  // store filled in descending order across the sign boundary, then one
  // value dropped mid-set and a closing beat that finds the store full;
  // a small set afterwards shows the drop flag cleared
  task automatic test_overflow();
    word_t vals[$];
    for (int k = 0; k < DEPTH + 2; k++) vals.push_back(word_t'((DEPTH / 2 - k) * 40000));
    send_set(vals);
    vals = '{32'sd9, -32'sd9, 32'sd0};
    send_set(vals);
    wait_for_results();
  endtask

  // receiver holds off while the sender keeps offering the next set
  task automatic test_backpressure();
    word_t vals[$];
    hold_request = 1'b1;
    repeat (6) vals.push_back(rand_value());
    send_set(vals);
    vals.delete();
    repeat (8) vals.push_back(rand_value());
    send_set(vals);
    wait_for_results();
  endtask

  // a few small random sets
  task automatic test_random_sets();
    word_t vals[$];
    int    sent;
    int    set_size;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_size = $urandom_range(1, 6);
      vals.delete();
      repeat (set_size) vals.push_back(rand_value());
      send_set(vals);
      sent += set_size;
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end
  endtask

  // main sequence
  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.value     <= '0;
    in_bus.last_item <= 1'b0;
    mismatch_count   = 0;
    burst_left       = 0;
    hold_request     = 1'b0;
    set_dropped      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_values();
    test_extremes();
    test_duplicates_and_reverse();
    test_overflow();
    test_backpressure();
    test_random_sets();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_sorted.size() != 0) begin
      $display("%0t: %0d sorted beats never arrived", $time, pending_sorted.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("bubble_sort_engine_core_tb: clean");
    end else begin
      $display("bubble_sort_engine_core_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: run timed out", $time);
    $display("bubble_sort_engine_core_tb: errors");
    $finish;
  end

endmodule : bubble_sort_engine_core_tb

// ----- bubble_sort_engine_core.f -----
hw/rtl/bse_pkg.sv
hw/rtl/bse_in_if.sv
hw/rtl/bse_out_if.sv
hw/rtl/bse_datapath.sv
hw/rtl/bse_ctrl.sv
hw/rtl/bubble_sort_engine_core.sv
tb/bubble_sort_engine_core_tb.sv
